// ===== sv/lzwc_pkg.sv =====
package lzwc_pkg;

  localparam int MAX_CODES    = 4096;
  localparam int SYMBOL_COUNT = 256;
  localparam int TABLE_DEPTH  = MAX_CODES - SYMBOL_COUNT;
  localparam int CODE_W       = $clog2(MAX_CODES);
  localparam int NFC_W        = CODE_W + 1;
  localparam int BYTE_W       = 8;
  localparam int OUT_W        = 12;
  localparam int LIMIT_W      = 13;
  localparam int ENTRY_W      = CODE_W + BYTE_W + CODE_W;

  // commands from the controller to the datapath
  typedef struct packed {
    logic clr_step;     // clear one hash slot
    logic load_in;      // capture input request
    logic set_first;    // first byte becomes the prefix
    logic start_probe;  // slot pointer <= hash of (prefix, byte)
    logic rd_slot;      // read hash slot
    logic rd_back;      // read back pointer of the slot's code
    logic next_probe;   // linear probe step
    logic hit;          // prefix <= found code
    logic miss_update;  // insert pair if room, prefix <= byte
    logic clear_stream; // dictionary reset
    logic emit;         // load the output register
    logic emit_last;
    logic in_ready;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic prefix_valid;
    logic eos;
    logic slot_live;
    logic back_match;
    logic key_match;
  } sts_t;

  function automatic logic [CODE_W-1:0] pair_hash(input logic [CODE_W-1:0] pre,
                                                 input logic [BYTE_W-1:0] b);
    logic [CODE_W-1:0] bx;
    bx = {b, {(CODE_W-BYTE_W){1'b0}}};
    return pre ^ bx;
  endfunction

endpackage

// ===== sv/lzwc_ctrl.sv =====
module lzwc_ctrl import lzwc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  sts_t sts,
  input  logic in_fire,
  input  logic out_free,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_DEC, S_RD, S_CHK1, S_CHK2, S_MISS, S_EOS
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_fire) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        if (!sts.prefix_valid) begin
          cmd.set_first = 1'b1;
          state_nxt     = sts.eos ? S_EOS : S_IDLE;
        end else begin
          cmd.start_probe = 1'b1;
          state_nxt       = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_slot = 1'b1;
        state_nxt   = S_CHK1;
      end
      S_CHK1: begin
        if (sts.slot_live) begin
          cmd.rd_back = 1'b1;
          state_nxt   = S_CHK2;
        end else begin
          state_nxt = S_MISS;
        end
      end
      S_CHK2: begin
        if (sts.back_match && sts.key_match) begin
          cmd.hit   = 1'b1;
          state_nxt = sts.eos ? S_EOS : S_IDLE;
        end else if (sts.back_match) begin
          cmd.next_probe = 1'b1;
          state_nxt      = S_RD;
        end else begin
          state_nxt = S_MISS;
        end
      end
      S_MISS: begin
        if (out_free) begin
          cmd.emit        = 1'b1;
          cmd.miss_update = 1'b1;
          state_nxt       = sts.eos ? S_EOS : S_IDLE;
        end
      end
      S_EOS: begin
        if (out_free) begin
          cmd.emit         = 1'b1;
          cmd.emit_last    = 1'b1;
          cmd.clear_stream = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/lzwc_dpath.sv =====
module lzwc_dpath import lzwc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  input  logic [BYTE_W-1:0]  in_byte,
  input  logic               in_eos,
  input  logic [LIMIT_W-1:0] dict_limit,
  output sts_t               sts,
  output logic [CODE_W-1:0]  prefix
);

  // hash slot entry: {prefix, byte, code}; code below 256 or not below
  // next free code marks an empty slot
  logic [ENTRY_W-1:0] hash_mem [MAX_CODES];
  logic [CODE_W-1:0]  back_mem [TABLE_DEPTH];

  logic [BYTE_W-1:0]  byte_r;
  logic               eos_r;
  logic [CODE_W-1:0]  prefix_r;
  logic               pvalid_r;
  logic [NFC_W-1:0]   nfc_r;
  logic [CODE_W-1:0]  slot_r;
  logic [CODE_W-1:0]  clr_r;
  logic [ENTRY_W-1:0] hq_r;
  logic [CODE_W-1:0]  bq_r;

  logic [CODE_W-1:0]  hq_code, hq_pre;
  logic [BYTE_W-1:0]  hq_byte;
  logic               can_insert;

  assign hq_code = hq_r[CODE_W-1:0];
  assign hq_byte = hq_r[CODE_W +: BYTE_W];
  assign hq_pre  = hq_r[CODE_W+BYTE_W +: CODE_W];

  always_comb begin
    if (32'(dict_limit) > 32'(MAX_CODES))
      can_insert = 32'(nfc_r) < 32'(MAX_CODES);
    else
      can_insert = 32'(nfc_r) < 32'(dict_limit);
  end

  assign sts.clr_last     = &clr_r;
  assign sts.prefix_valid = pvalid_r;
  assign sts.eos          = eos_r;
  assign sts.slot_live    = (32'(hq_code) >= 32'(SYMBOL_COUNT)) &&
                            (NFC_W'(hq_code) < nfc_r);
  assign sts.back_match   = bq_r == slot_r;
  assign sts.key_match    = (hq_pre == prefix_r) && (hq_byte == byte_r);
  assign prefix           = prefix_r;

  // memories
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      hash_mem[clr_r] <= '0;
    end else if (cmd.miss_update && can_insert) begin
      hash_mem[slot_r] <= {prefix_r, byte_r, nfc_r[CODE_W-1:0]};
    end
    if (cmd.miss_update && can_insert) begin
      back_mem[CODE_W'(nfc_r - NFC_W'(SYMBOL_COUNT))] <= slot_r;
    end
    if (cmd.rd_slot) hq_r <= hash_mem[slot_r];
    if (cmd.rd_back) bq_r <= back_mem[CODE_W'(hq_code - CODE_W'(SYMBOL_COUNT))];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      byte_r <= in_byte;
      eos_r  <= in_eos;
    end
    if (cmd.start_probe) slot_r <= pair_hash(prefix_r, byte_r);
    else if (cmd.next_probe) slot_r <= slot_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= '0;
      pvalid_r <= 1'b0;
      nfc_r    <= NFC_W'(SYMBOL_COUNT);
      clr_r    <= '0;
    end else begin
      if (cmd.clr_step) clr_r <= clr_r + 1'b1;
      if (cmd.set_first) begin
        prefix_r <= CODE_W'(byte_r);
        pvalid_r <= 1'b1;
      end
      if (cmd.hit) prefix_r <= hq_code;
      if (cmd.miss_update) begin
        prefix_r <= CODE_W'(byte_r);
        if (can_insert) nfc_r <= nfc_r + 1'b1;
      end
      if (cmd.clear_stream) begin
        prefix_r <= '0;
        pvalid_r <= 1'b0;
        nfc_r    <= NFC_W'(SYMBOL_COUNT);
      end
    end
  end

endmodule

// ===== sv/lzw_compressor.sv =====
// LZW compressor with 12-bit codes. Each input request carries one byte
// (in_tdata) and an end-of-stream mark (in_tlast). Codes leave on the out_
// channel, with out_tlast high on the final code of a stream, after which the
// dictionary starts over. The dictionary is a hash table (4096 slots, linear
// probing) plus a code-to-slot table that tells live slots from stale ones,
// so a new stream needs no clearing. After reset a clearing pass over every
// slot runs once. in_tready stays low during it, and cfg writes are taken.
// A byte that opens a stream only becomes the prefix. Any other byte is
// hashed, then its slot is read and checked; a live slot also has its
// back pointer read and checked, and a live slot whose key differs makes
// it probe the next slot. A miss at an empty or stale slot emits a code. A
// byte with the end mark adds a step for the final code. Any wait on
// out_tready for a code stalls the byte. cfg_data is dict_limit: entries
// stop being added once the next free code reaches it (values above 4096 act as 4096).
module lzw_compressor import lzwc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [11:0] out_code, [15:12] zero
  output logic        out_tlast,  // last_code
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data    // dict_limit
);

  cmd_t               cmd;
  sts_t               sts;
  logic [CODE_W-1:0]  prefix;
  logic [LIMIT_W-1:0] limit_r;
  logic               out_valid_r;
  logic [OUT_W-1:0]   out_code_r;
  logic               out_last_r;
  logic               out_free;
  logic               in_fire;

  assign cfg_ready  = 1'b1;
  assign in_tready  = cmd.in_ready;
  assign in_fire    = in_tvalid && cmd.in_ready;
  // output register frees up in the same cycle it is taken
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = 16'(out_code_r);
  assign out_tlast  = out_last_r;

  lzwc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .sts      (sts),
    .in_fire  (in_fire),
    .out_free (out_free),
    .cmd      (cmd)
  );

  lzwc_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_byte    (in_tdata),
    .in_eos     (in_tlast),
    .dict_limit (limit_r),
    .sts        (sts),
    .prefix     (prefix)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_W'(MAX_CODES);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) limit_r <= cfg_data;
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_code_r <= OUT_W'(prefix);
      out_last_r <= cmd.emit_last;
    end
  end

endmodule
